/* rtl/accel_tilt_roll_pitch_top_macros.svh */
// Assertion macros used by the checker file of the tilt block.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ACCEL_TILT_ROLL_PITCH_TOP_MACROS_SVH
`define ACCEL_TILT_ROLL_PITCH_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ATRP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tilt block assertion failed");

// Next-cycle implication, checked out of reset.
`define ATRP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tilt block assertion failed");

`endif

/* rtl/atrp_pkg.sv */
// Package for the accelerometer tilt block: widths, CORDIC step table,
// the pipeline cell record and the angle finishing function.
// No dependencies.
package atrp_pkg;

    localparam int IN_W      = 16;
    localparam int ROLL_W    = 16;
    localparam int PITCH_W   = 15;
    // Datapath: 16-bit sample scaled by 2^24 plus CORDIC growth
    localparam int DATA_W    = 43;
    localparam int DATA_SHIFT = 24;
    // Angle accumulator in 2^-16 degree
    localparam int ACC_W     = 26;
    localparam int ACC_FRAC  = 16;
    localparam int SIDE_W    = IN_W + 1;
    localparam int MAX_STEPS = 24;

    // Gain correction: (mag >> 8) * (1/K in Q30) >> 22
    localparam int GAIN_PRE_SHIFT  = 8;
    localparam int GAIN_POST_SHIFT = 22;
    localparam int GAIN_CONST_W    = 30;
    localparam int MAG_W           = DATA_W - 1 - GAIN_PRE_SHIFT;
    localparam int MAG_HALF_W      = (MAG_W + 1) / 2;
    localparam int PROD_W          = MAG_HALF_W + GAIN_CONST_W;
    localparam int FULL_W          = MAG_W + GAIN_CONST_W;
    localparam int R_W             = FULL_W - GAIN_POST_SHIFT;
    localparam logic [GAIN_CONST_W-1:0] INV_GAIN = 30'd652032874;

    localparam logic signed [ACC_W-1:0] DEG180 = 26'sd11796480;
    localparam logic signed [ACC_W-1:0] DEG90  = 26'sd5898240;

    // One stage of a CORDIC chain
    typedef struct packed {
        logic                     valid;
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [ACC_W-1:0]  acc;
        logic [SIDE_W-1:0]        side;
    } cell_t;

    // atan(2^-i) in 2^-16 degree, rounded to nearest
    function automatic logic signed [ACC_W-1:0] step_angle(input int unsigned idx);
        logic signed [ACC_W-1:0] a;
        case (idx)
            0:       a = 26'sd2949120;
            1:       a = 26'sd1740967;
            2:       a = 26'sd919879;
            3:       a = 26'sd466945;
            4:       a = 26'sd234379;
            5:       a = 26'sd117265;
            6:       a = 26'sd58666;
            7:       a = 26'sd29335;
            8:       a = 26'sd14668;
            9:       a = 26'sd7334;
            10:      a = 26'sd3667;
            11:      a = 26'sd1833;
            12:      a = 26'sd917;
            13:      a = 26'sd458;
            14:      a = 26'sd229;
            15:      a = 26'sd115;
            16:      a = 26'sd57;
            17:      a = 26'sd29;
            18:      a = 26'sd14;
            19:      a = 26'sd7;
            20:      a = 26'sd4;
            21:      a = 26'sd2;
            22:      a = 26'sd1;
            default: a = '0;
        endcase
        return a;
    endfunction

    // Saturate to +-lim, then round to nearest (ties up) and drop shift bits
    function automatic logic signed [ACC_W-1:0] finish_angle(
        input logic signed [ACC_W-1:0] acc,
        input logic signed [ACC_W-1:0] lim,
        input int unsigned             shift
    );
        logic signed [ACC_W-1:0] sat;
        logic signed [ACC_W-1:0] one;
        logic signed [ACC_W-1:0] rnd;
        sat = acc;
        one = 1;
        if (acc > lim)
            sat = lim;
        if (acc < -lim)
            sat = -lim;
        rnd = (shift > 0) ? (one << (shift - 1)) : '0;
        return (sat + rnd) >>> shift;
    endfunction

endpackage

/* rtl/accel_tilt_roll_pitch_top.sv */
// Top level of the accelerometer tilt block: roll and pitch by two CORDIC
// chains. Depends on atrp_pkg, atrp_cell and atrp_gain.
//
//  channel   dir  fields (low bit first)                         transaction when
//  s_*       in   tdata: accel_x[15:0] accel_y[31:16] accel_z[47:32]  s_tvalid & s_tready
//  m_*       out  tdata: roll_angle[15:0] pitch_angle[30:16] pad[31]  m_tvalid & m_tready
//
// One sample per cycle while the output is not stalled; the pipeline is the input
// stage, roll chain, two gain-correction stages, pitch chain and output register.
// Reset clears all stage valid bits; there is no stored state between samples.
// A stalled output register freezes the whole pipeline; s_tready follows it.
module accel_tilt_roll_pitch_top #(
    parameter int ROTATION_STEPS      = 16,
    parameter int ANGLE_FRACTION_BITS = 7
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [3*atrp_pkg::IN_W-1:0]   s_tdata,   // accel_x, accel_y, accel_z
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [31:0]                   m_tdata    // roll_angle, pitch_angle, zero pad
);
    import atrp_pkg::*;

    localparam int unsigned FRAC_SHIFT = ACC_FRAC - ANGLE_FRACTION_BITS;

    logic                     en;
    logic signed [IN_W-1:0]   ax;
    logic signed [IN_W-1:0]   ay;
    logic signed [IN_W-1:0]   az;
    logic signed [DATA_W-1:0] y_scaled;
    logic signed [DATA_W-1:0] z_scaled;
    logic                     z_neg;
    cell_t                    prep_next;
    cell_t                    prep_reg;
    cell_t                    roll_q  [0:ROTATION_STEPS];
    cell_t                    pitch_q [0:ROTATION_STEPS];

    logic signed [ACC_W-1:0]  pitch_fin;
    logic                     out_valid_reg;
    logic [ROLL_W-1:0]        roll_reg;
    logic [PITCH_W-1:0]       pitch_reg;

    // Pipeline moves whenever the output register is free or drained
    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    assign ax = s_tdata[IN_W-1:0];
    assign ay = s_tdata[2*IN_W-1:IN_W];
    assign az = s_tdata[3*IN_W-1:2*IN_W];

    assign y_scaled = DATA_W'(ay) <<< DATA_SHIFT;
    assign z_scaled = DATA_W'(az) <<< DATA_SHIFT;
    assign z_neg    = az[IN_W-1];

    // Input stage: turn left-half vectors by 180 degrees, preload offset
    always_comb
    begin
        prep_next.valid = s_tvalid;
        prep_next.x     = z_neg ? -z_scaled : z_scaled;
        prep_next.y     = z_neg ? -y_scaled : y_scaled;
        if (!z_neg)
            prep_next.acc = '0;
        else if (!ay[IN_W-1])
            prep_next.acc = DEG180;
        else
            prep_next.acc = -DEG180;
        prep_next.side  = {(ay == '0) && (az == '0), ax};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prep_reg <= '0;
        else if (en)
            prep_reg <= prep_next;
    end

    assign roll_q[0] = prep_reg;

    // Roll chain: atan2(y, z) and the scaled magnitude
    for (genvar i = 0; i < ROTATION_STEPS; i++)
    begin : g_roll
        atrp_cell #(
            .STEP (i)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .d_in  (roll_q[i]),
            .d_out (roll_q[i+1])
        );
    end

    atrp_gain #(
        .ANGLE_FRACTION_BITS (ANGLE_FRACTION_BITS)
    ) u_gain (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .d_in  (roll_q[ROTATION_STEPS]),
        .d_out (pitch_q[0])
    );

    // Pitch chain: atan2(-x, magnitude)
    for (genvar i = 0; i < ROTATION_STEPS; i++)
    begin : g_pitch
        atrp_cell #(
            .STEP (i)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .d_in  (pitch_q[i]),
            .d_out (pitch_q[i+1])
        );
    end

    // Output register: finish pitch, hold the result until taken
    assign pitch_fin = pitch_q[ROTATION_STEPS].side[SIDE_W-1] ? '0 :
                       finish_angle(pitch_q[ROTATION_STEPS].acc, DEG90, FRAC_SHIFT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= pitch_q[ROTATION_STEPS].valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            roll_reg  <= pitch_q[ROTATION_STEPS].side[ROLL_W-1:0];
            pitch_reg <= pitch_fin[PITCH_W-1:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, pitch_reg, roll_reg};

endmodule

/* rtl/atrp_cell.sv */
// One CORDIC vectoring cell: a single micro-rotation per cycle while en is high.
// Depends on atrp_pkg (cell_t, step_angle).
module atrp_cell #(
    parameter int STEP = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  atrp_pkg::cell_t d_in,
    output atrp_pkg::cell_t d_out
);
    import atrp_pkg::*;

    localparam logic signed [ACC_W-1:0] ANGLE = step_angle(STEP);

    logic signed [DATA_W-1:0] dx;
    logic signed [DATA_W-1:0] dy;
    cell_t                    d_next;
    cell_t                    d_reg;

    assign dx = d_in.y >>> STEP;
    assign dy = d_in.x >>> STEP;

    // Rotate toward y = 0 and accumulate the step angle
    always_comb
    begin
        d_next = d_in;
        if (d_in.y[DATA_W-1])
        begin
            d_next.x   = d_in.x - dx;
            d_next.y   = d_in.y + dy;
            d_next.acc = d_in.acc - ANGLE;
        end
        else
        begin
            d_next.x   = d_in.x + dx;
            d_next.y   = d_in.y - dy;
            d_next.acc = d_in.acc + ANGLE;
        end
    end

    // Advance one stage when the pipeline moves
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_reg <= '0;
        else if (en)
            d_reg <= d_next;
    end

    assign d_out = d_reg;

endmodule

/* rtl/atrp_gain.sv */
// Gain correction between the roll and pitch chains (two stages).
// Finishes the roll angle and loads the pitch vector. Depends on atrp_pkg.
module atrp_gain #(
    parameter int ANGLE_FRACTION_BITS = 7
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  atrp_pkg::cell_t d_in,
    output atrp_pkg::cell_t d_out
);
    import atrp_pkg::*;

    localparam int unsigned FRAC_SHIFT = ACC_FRAC - ANGLE_FRACTION_BITS;

    logic signed [DATA_W-1:0] mag_clamp;
    logic [MAG_W-1:0]         mag_pre;
    logic [PROD_W-1:0]        prod_lo_next;
    logic [PROD_W-1:0]        prod_hi_next;

    logic                     valid_a_reg;
    logic [PROD_W-1:0]        prod_lo_reg;
    logic [PROD_W-1:0]        prod_hi_reg;
    logic signed [ACC_W-1:0]  roll_acc_reg;
    logic [SIDE_W-1:0]        side_a_reg;

    logic [FULL_W-1:0]        full_prod;
    logic [R_W-1:0]           mag_corr;
    logic signed [IN_W-1:0]   ax;
    logic signed [DATA_W-1:0] ax_ext;
    logic signed [ACC_W-1:0]  roll_fin;
    logic                     roll_zero;
    logic                     pitch_zero;
    cell_t                    d_next;
    cell_t                    d_reg;

    // Stage A: clamp magnitude, split it and multiply both halves by 1/K
    assign mag_clamp    = d_in.x[DATA_W-1] ? '0 : d_in.x;
    assign mag_pre      = mag_clamp[DATA_W-2:GAIN_PRE_SHIFT];
    assign prod_lo_next = PROD_W'(mag_pre[MAG_HALF_W-1:0]) * PROD_W'(INV_GAIN);
    assign prod_hi_next = PROD_W'(mag_pre[MAG_W-1:MAG_HALF_W]) * PROD_W'(INV_GAIN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_a_reg <= 1'b0;
        else if (en)
            valid_a_reg <= d_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_lo_reg  <= prod_lo_next;
            prod_hi_reg  <= prod_hi_next;
            roll_acc_reg <= d_in.acc;
            side_a_reg   <= d_in.side;
        end
    end

    // Stage B: sum partial products, finish roll, build the pitch vector
    assign full_prod  = (FULL_W'(prod_hi_reg) << MAG_HALF_W) + FULL_W'(prod_lo_reg);
    assign mag_corr   = full_prod[FULL_W-1:GAIN_POST_SHIFT];
    assign ax         = side_a_reg[IN_W-1:0];
    assign roll_zero  = side_a_reg[SIDE_W-1];
    assign ax_ext     = DATA_W'(ax);
    assign roll_fin   = roll_zero ? '0 : finish_angle(roll_acc_reg, DEG180, FRAC_SHIFT);
    assign pitch_zero = (mag_corr == '0) && (ax == '0);

    always_comb
    begin
        d_next.valid = valid_a_reg;
        d_next.x     = DATA_W'(mag_corr);
        d_next.y     = -(ax_ext <<< DATA_SHIFT);
        d_next.acc   = '0;
        d_next.side  = {pitch_zero, roll_fin[ROLL_W-1:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_reg <= '0;
        else if (en)
            d_reg <= d_next;
    end

    assign d_out = d_reg;

endmodule

/* rtl/atrp_checker.sv */
// Port-level checker for the tilt block, bound to the top level.
// Depends on accel_tilt_roll_pitch_top_macros.svh.
`include "accel_tilt_roll_pitch_top_macros.svh"

module atrp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // A stalled result stays offered and unchanged
    `ATRP_ASSERT_NEXT(a_out_hold_valid, m_tvalid && !m_tready, m_tvalid)
    `ATRP_ASSERT_NEXT(a_out_hold_data, m_tvalid && !m_tready, $stable(m_tdata))

    // A stalled output freezes intake; an empty output never blocks it
    `ATRP_ASSERT_SAME(a_stall_blocks_in, m_tvalid && !m_tready, !s_tready)
    `ATRP_ASSERT_SAME(a_empty_takes_in, !m_tvalid, s_tready)

    // Pad bit above the pitch field stays clear
    `ATRP_ASSERT_SAME(a_pad_zero, m_tvalid, m_tdata[31] == 1'b0)

endmodule

bind accel_tilt_roll_pitch_top atrp_checker u_atrp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* verif/tb_top.sv */
// Self-checking testbench for accel_tilt_roll_pitch_top: roll and pitch from raw X/Y/Z samples.
// Holds its own CORDIC angle predictor; depends on atrp_pkg and the block's RTL only.
`timescale 1ns / 100ps

module tb_top;

    import atrp_pkg::*;

    localparam int ROTATION_STEPS      = 16;
    localparam int ANGLE_FRACTION_BITS = 7;
    localparam int LATENCY             = 2 * ROTATION_STEPS + 4;
    localparam int CYCLE_LIMIT         = 100000;
    localparam int MAX_REPORTS         = 10;
    localparam int IDLE_PERCENT        = 9;
    // accumulator is in 2^-16 degree
    localparam int DEG_FRAC            = 16;
    localparam int ROUND_SHIFT         = DEG_FRAC - ANGLE_FRACTION_BITS;
    localparam longint SAMPLE_SCALE    = 64'sd16777216;
    localparam longint unsigned RECIP_GAIN_Q30 = 64'd652032874;
    localparam longint HALF_TURN       = 64'sd180 <<< DEG_FRAC;
    localparam longint QUARTER_TURN    = 64'sd90 <<< DEG_FRAC;

    // atan(2^-i) in 2^-16 degree
    localparam longint ATAN_DEG [0:23] = '{
        2949120, 1740967, 919879, 466945, 234379, 117265, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    typedef struct packed {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic [15:0]        roll;
        logic [14:0]        pitch;
    } tilt_rec_t;

    logic                  clk;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [3*IN_W-1:0]     s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [31:0]           m_tdata;

    logic                  quiet = 1'b0;
    int                    cycle_count = 0;
    int                    mismatch_count = 0;
    tilt_rec_t             pending_angles[$];

    accel_tilt_roll_pitch_top #(
        .ROTATION_STEPS      (ROTATION_STEPS),
        .ANGLE_FRACTION_BITS (ANGLE_FRACTION_BITS)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // accel_x, accel_y, accel_z
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)     // roll_angle, pitch_angle, zero pad
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Drive y toward zero; return the summed angle and leave the scaled length in len
    function automatic longint cordic_vectoring(input longint x_in, input longint y_in,
                                                output longint len);
        longint x;
        longint y;
        longint dx;
        longint dy;
        longint angle;
        x = x_in;
        y = y_in;
        angle = 0;
        for (int i = 0; i < ROTATION_STEPS && i < 24; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y < 0)
            begin
                x = x - dx;
                y = y + dy;
                angle = angle - ATAN_DEG[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                angle = angle + ATAN_DEG[i];
            end
        end
        len = x;
        return angle;
    endfunction

    // Clamp to +-bound, round to nearest with ties up, drop the extra fraction bits
    function automatic longint round_angle(input longint angle, input longint bound);
        longint a;
        a = angle;
        if (a > bound)
            a = bound;
        if (a < -bound)
            a = -bound;
        if (ROUND_SHIFT > 0)
            a = a + (64'sd1 <<< (ROUND_SHIFT - 1));
        return a >>> ROUND_SHIFT;
    endfunction

    function automatic tilt_rec_t tilt_from_accel(input logic signed [15:0] ax,
                                                  input logic signed [15:0] ay,
                                                  input logic signed [15:0] az);
        tilt_rec_t rec;
        longint roll_acc;
        longint pitch_acc;
        longint len;
        longint unused_len;
        longint vx;
        longint vy;
        longint half;
        longint px;
        longint py;
        longint roll_v;
        longint pitch_v;
        longint unsigned ulen;
        roll_acc = 0;
        pitch_acc = 0;
        len = 0;
        // roll pass; fold the left half plane over by 180 degrees first
        if (ay != 0 || az != 0)
        begin
            vx = longint'(az) * SAMPLE_SCALE;
            vy = longint'(ay) * SAMPLE_SCALE;
            half = 0;
            if (az < 0)
            begin
                vx = -vx;
                vy = -vy;
                half = (ay >= 0) ? HALF_TURN : -HALF_TURN;
            end
            roll_acc = cordic_vectoring(vx, vy, len) + half;
        end
        if (len < 0)
            len = 0;
        // remove the CORDIC gain from the length
        ulen = len;
        px = longint'(((ulen >> 8) * RECIP_GAIN_Q30) >> 22);
        py = -longint'(ax) * SAMPLE_SCALE;
        if (px != 0 || py != 0)
            pitch_acc = cordic_vectoring(px, py, unused_len);
        roll_v = round_angle(roll_acc, HALF_TURN);
        pitch_v = round_angle(pitch_acc, QUARTER_TURN);
        rec.ax = ax;
        rec.ay = ay;
        rec.az = az;
        rec.roll = roll_v[15:0];
        rec.pitch = pitch_v[14:0];
        return rec;
    endfunction

    // Record the expected angles for each accepted sample transaction
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            pending_angles.push_back(tilt_from_accel(s_tdata[15:0], s_tdata[31:16],
                                                     s_tdata[47:32]));
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin
        tilt_rec_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_angles.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result: roll=%0d pitch=%0d",
                             $signed(m_tdata[15:0]), $signed(m_tdata[30:16]));
            end
            else
            begin
                want = pending_angles.pop_front();
                if (m_tdata[15:0] !== want.roll || m_tdata[30:16] !== want.pitch)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $write("mismatch x=%0d y=%0d z=%0d: roll exp %0d got %0d, ",
                               want.ax, want.ay, want.az,
                               $signed(want.roll), $signed(m_tdata[15:0]));
                        $display("pitch exp %0d got %0d",
                                 $signed(want.pitch), $signed(m_tdata[30:16]));
                    end
                end
            end
        end
    end

    // Stall the result side at random unless in a quiet stretch
    always @(posedge clk)
        m_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PERCENT);

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // Abort a hung run
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("FAIL accel_tilt_roll_pitch_top");
        $finish;
    end

    // Present one sample and hold it until the transaction completes
    task automatic send_accel(input logic signed [15:0] ax, input logic signed [15:0] ay,
                              input logic signed [15:0] az);
        while (!quiet && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {az, ay, ax};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Hold off the sender until every expected result is back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_angles.size() != 0);
    endtask

    function automatic logic signed [15:0] near_zero();
        return 16'($signed($urandom_range(0, 8)) - 4);
    endfunction

    task automatic test_directed();
        send_accel(0, 0, 0);
        send_accel(0, 0, 1000);
        // y zero with z negative lands on +180
        send_accel(0, 0, -1000);
        send_accel(0, 500, -1000);
        send_accel(0, -500, -1000);
        send_accel(0, 1000, 0);
        send_accel(0, -1000, 0);
        // zero length with x set: pitch pinned at +-90
        send_accel(1000, 0, 0);
        send_accel(-1000, 0, 0);
        send_accel(32767, 0, 0);
        send_accel(-32768, 0, 0);
        send_accel(0, 32767, 32767);
        send_accel(0, -32768, -32768);
        send_accel(0, -32768, 0);
        send_accel(0, 0, -32768);
        send_accel(0, 0, 32767);
        send_accel(32767, 32767, 32767);
        send_accel(-32768, -32768, -32768);
        send_accel(-32768, 32767, -32768);
        send_accel(1, 1, 1);
        send_accel(-1, 0, -1);
        send_accel(0, -1, -1);
        send_accel(16384, 0, 16384);
        send_accel(-16384, 1, -32768);
    endtask

    task automatic test_random_full(input int count);
        for (int n = 0; n < count; n++)
            send_accel(16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    // Run with neither side idling
    task automatic test_back_to_back(input int count);
        quiet = 1'b1;
        test_random_full(count);
        quiet = 1'b0;
    endtask

    // Values around zero, where the half-plane folds and the zero cases live
    task automatic test_near_zero(input int count);
        for (int n = 0; n < count; n++)
            send_accel(near_zero(), near_zero(), near_zero());
    endtask

    // Clear one or two axes at random
    task automatic test_axis_aligned(input int count);
        logic signed [15:0] v[3];
        int                 pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 5);
            for (int k = 0; k < 3; k++)
                v[k] = 16'($urandom);
            case (pick)
                0: v[0] = 0;
                1: v[1] = 0;
                2: v[2] = 0;
                3:
                begin
                    v[1] = 0;
                    v[2] = 0;
                end
                4:
                begin
                    v[0] = 0;
                    v[2] = 0;
                end
                default:
                begin
                    v[1] = 0;
                    v[0] = 0;
                end
            endcase
            send_accel(v[0], v[1], v[2]);
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        drain_results();
        test_random_full(300);
        test_back_to_back(200);
        drain_results();
        test_near_zero(200);
        test_axis_aligned(200);
        test_random_full(100);
        drain_results();
        repeat (2 * LATENCY) @(posedge clk);
        if (pending_angles.size() != 0)
            mismatch_count++;
        if (mismatch_count == 0)
            $display("PASS accel_tilt_roll_pitch_top");
        else
            $display("FAIL accel_tilt_roll_pitch_top");
        $finish;
    end

endmodule
